// ===== hw/rtl/achc_pkg.sv =====
`timescale 1ns / 1ps
// shared widths, codes, reset values and types of the capture high-pass block
// no dependencies
package achc_pkg;

    localparam int RAW_W       = 12;
    localparam int NUM_RAW     = 4;
    localparam int SUM_W       = RAW_W + 2;
    localparam int DC_W        = 12;
    localparam int GAIN_W      = 4;
    localparam int ALPHA_W     = 16;
    localparam int CLEN_W      = 17;
    localparam int X_W         = 16;
    localparam int DX_W        = X_W + 1;
    localparam int AD_W        = DX_W + ALPHA_W + 1;
    localparam int Y_W         = 40;
    localparam int FRAC_W      = 16;
    localparam int LANES       = 4;
    localparam int SLICE_W     = Y_W / LANES;
    localparam int LANE_W      = SLICE_W + 1 + ALPHA_W + 1;
    localparam int PROD_W      = Y_W + ALPHA_W + 1;
    localparam int SAMPLE_W    = 12;
    localparam int INDEX_W     = 16;
    localparam int MAX_SAMPLES = 65536;
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_AW     = 3;
    localparam int PEND_W      = FIFO_AW + 1;
    localparam int S_DATA_W    = 48;
    localparam int M_DATA_W    = 32;

    localparam int SAMPLE_MAX  = 2046;
    localparam int SAMPLE_MIN  = -2047;

    // configuration register indexes
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 17;
    localparam logic [CFG_ADDR_W-1:0] CFG_ZERO_LEVEL = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN       = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ALPHA      = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_CLEN       = 2'd3;

    localparam logic [DC_W-1:0]    ZERO_LEVEL_RST = 12'd2047;
    localparam logic [GAIN_W-1:0]  GAIN_RST       = 4'd2;
    localparam logic [ALPHA_W-1:0] ALPHA_RST      = 16'd62259;
    localparam logic [CLEN_W-1:0]  CLEN_RST       = 17'd44000;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic               last;
    } tag_t;

    typedef struct packed {
        logic                   valid;
        logic signed [AD_W-1:0] ad;
        tag_t                   tag;
    } front_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        tag_t                       tag;
    } result_t;

    typedef struct packed {
        logic [DC_W-1:0]    zero_level;
        logic [GAIN_W-1:0]  gain;
        logic [ALPHA_W-1:0] alpha;
    } coef_t;

endpackage

// ===== hw/rtl/achc_mul_lane.sv =====
`timescale 1ns / 1ps
// one lane of the filter feedback multiply: a slice of the stored output times alpha
// depends on achc_pkg
module achc_mul_lane (
    input  logic signed [achc_pkg::SLICE_W:0]     slice,
    input  logic        [achc_pkg::ALPHA_W-1:0]   alpha,
    output logic signed [achc_pkg::LANE_W-1:0]    prod
);

    logic signed [achc_pkg::ALPHA_W:0] alpha_s;

    assign alpha_s = $signed({1'b0, alpha});
    assign prod    = slice * alpha_s;

endmodule

// ===== hw/rtl/achc_front.sv =====
`timescale 1ns / 1ps
// front stages: average, offset, gain with saturation, then alpha * (x - x_prev)
// depends on achc_pkg
module achc_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [achc_pkg::SUM_W-1:0]   sum,
    input  achc_pkg::tag_t               tag,
    input  achc_pkg::coef_t              coef,
    output achc_pkg::front_t             out
);

    logic                                 v2_reg;
    logic                                 v3_reg;
    achc_pkg::tag_t                       tag2_reg;
    achc_pkg::tag_t                       tag3_reg;
    logic signed [achc_pkg::X_W-1:0]      x_reg;
    logic signed [achc_pkg::X_W-1:0]      x_next;
    logic signed [achc_pkg::X_W-1:0]      xprev_reg;
    logic signed [achc_pkg::AD_W-1:0]     ad_reg;

    logic        [achc_pkg::RAW_W-1:0]    avg;
    logic signed [achc_pkg::RAW_W:0]      centered;
    logic signed [achc_pkg::GAIN_W:0]     gain_s;
    logic signed [achc_pkg::RAW_W+achc_pkg::GAIN_W+1:0] scaled;
    logic signed [achc_pkg::DX_W-1:0]     dx;
    logic signed [achc_pkg::ALPHA_W:0]    alpha_s;
    logic signed [achc_pkg::AD_W-1:0]     ad;

    localparam int SC_W = achc_pkg::RAW_W + achc_pkg::GAIN_W + 2;

    always_comb
    begin
        avg      = sum[achc_pkg::SUM_W-1:2];
        centered = $signed({1'b0, avg}) - $signed({1'b0, coef.zero_level});
        gain_s   = $signed({1'b0, coef.gain});
        scaled   = centered * gain_s;
        // saturate to 16 bits when the top bits disagree
        if (scaled[SC_W-1:achc_pkg::X_W-1] == '0 || scaled[SC_W-1:achc_pkg::X_W-1] == '1)
        begin
            x_next = scaled[achc_pkg::X_W-1:0];
        end
        else if (scaled[SC_W-1])
        begin
            x_next = {1'b1, {(achc_pkg::X_W-1){1'b0}}};
        end
        else
        begin
            x_next = {1'b0, {(achc_pkg::X_W-1){1'b1}}};
        end
    end

    always_comb
    begin
        dx      = $signed({x_reg[achc_pkg::X_W-1], x_reg})
                - $signed({xprev_reg[achc_pkg::X_W-1], xprev_reg});
        alpha_s = $signed({1'b0, coef.alpha});
        ad      = dx * alpha_s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            xprev_reg <= '0;
        end
        else
        begin
            v2_reg <= in_valid;
            v3_reg <= v2_reg;
            if (v2_reg)
            begin
                xprev_reg <= x_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        tag2_reg <= tag;
        ad_reg   <= ad;
        tag3_reg <= tag2_reg;
    end

    assign out = '{valid: v3_reg, ad: ad_reg, tag: tag3_reg};

endmodule

// ===== hw/rtl/achc_filter.sv =====
`timescale 1ns / 1ps
// high-pass feedback stage: lane multipliers, merge, saturation, output rounding and clip
// depends on achc_pkg and achc_mul_lane
module achc_filter (
    input  logic                            clk,
    input  logic                            rst_n,
    input  achc_pkg::front_t                in,
    input  logic [achc_pkg::ALPHA_W-1:0]    alpha,
    output logic                            push,
    output achc_pkg::result_t               result
);

    localparam int YS_W = achc_pkg::PROD_W - achc_pkg::FRAC_W + 1;
    localparam int Q_W  = achc_pkg::Y_W - achc_pkg::FRAC_W + 1;

    logic signed [achc_pkg::Y_W-1:0]      y_reg;
    logic signed [achc_pkg::Y_W-1:0]      y_next;
    logic                                 v4_reg;
    achc_pkg::tag_t                       tag4_reg;

    logic signed [achc_pkg::LANE_W-1:0]   lane_prod [achc_pkg::LANES];
    logic signed [achc_pkg::PROD_W-1:0]   p;
    logic signed [YS_W-1:0]               ysum;
    logic signed [achc_pkg::Y_W:0]        ytz;
    logic signed [Q_W-1:0]                q;

    for (genvar l = 0; l < achc_pkg::LANES; l++)
    begin : g_lane
        logic signed [achc_pkg::SLICE_W:0] slice;
        if (l == achc_pkg::LANES - 1)
        begin : g_top
            assign slice = $signed({y_reg[achc_pkg::Y_W-1],
                                    y_reg[l*achc_pkg::SLICE_W +: achc_pkg::SLICE_W]});
        end
        else
        begin : g_low
            assign slice = $signed({1'b0, y_reg[l*achc_pkg::SLICE_W +: achc_pkg::SLICE_W]});
        end
        achc_mul_lane u_lane (
            .slice (slice),
            .alpha (alpha),
            .prod  (lane_prod[l])
        );
    end

    // merge lanes, then y = alpha*dx + floor(alpha*y_prev / 2^16)
    always_comb
    begin
        p = '0;
        for (int l = 0; l < achc_pkg::LANES; l++)
        begin
            p = p + (achc_pkg::PROD_W'(lane_prod[l]) <<< (l * achc_pkg::SLICE_W));
        end
        ysum = YS_W'($signed(p[achc_pkg::PROD_W-1:achc_pkg::FRAC_W])) + YS_W'(in.ad);
        if (ysum[YS_W-1:achc_pkg::Y_W-1] == '0 || ysum[YS_W-1:achc_pkg::Y_W-1] == '1)
        begin
            y_next = ysum[achc_pkg::Y_W-1:0];
        end
        else if (ysum[YS_W-1])
        begin
            y_next = {1'b1, {(achc_pkg::Y_W-1){1'b0}}};
        end
        else
        begin
            y_next = {1'b0, {(achc_pkg::Y_W-1){1'b1}}};
        end
    end

    // truncate toward zero: bias negatives before the arithmetic shift
    always_comb
    begin
        ytz = $signed({y_reg[achc_pkg::Y_W-1], y_reg})
            + $signed({{(achc_pkg::Y_W+1-achc_pkg::FRAC_W){1'b0}},
                       {achc_pkg::FRAC_W{y_reg[achc_pkg::Y_W-1]}}});
        q   = ytz[achc_pkg::Y_W:achc_pkg::FRAC_W];
        result.tag = tag4_reg;
        if (q > Q_W'(achc_pkg::SAMPLE_MAX))
        begin
            result.sample = achc_pkg::SAMPLE_W'(achc_pkg::SAMPLE_MAX);
        end
        else if (q < Q_W'(achc_pkg::SAMPLE_MIN))
        begin
            result.sample = achc_pkg::SAMPLE_W'(achc_pkg::SAMPLE_MIN);
        end
        else
        begin
            result.sample = q[achc_pkg::SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y_reg  <= '0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= in.valid;
            if (in.valid)
            begin
                y_reg <= y_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tag4_reg <= in.tag;
    end

    assign push = v4_reg;

endmodule

// ===== hw/rtl/audio_capture_highpass_clip.sv =====
`timescale 1ns / 1ps
// top level: config registers, capture control, pipeline and output queue
// depends on achc_pkg, achc_front and achc_filter
//
// input stream s_*: one item holds four 12-bit readings in s_tdata and the
// restart flag in s_tuser. an item with restart set opens a new capture.
// items outside a running capture, or past the capture length, are taken
// and dropped without a result.
// output stream m_*: one result per kept item, sample and index in m_tdata,
// m_tlast high on the sample that completes the capture.
// config port: cfg_we writes cfg_wdata to register cfg_addr
// (0 zero level, 1 gain, 2 alpha, 3 capture length); write only when idle.
// registers: input, front x, front alpha*dx, filter output, then the queue.
// throughput: one item per cycle while s_tready is high; the filter feedback
// (lane multiply of stored output by alpha, merge, saturate) is combinational.
// an 8-entry output queue absorbs stalls; s_tready drops only when every
// queue slot is claimed by an item in flight or waiting.
// reset: config goes to its defaults, filter state and count to zero,
// capture idle, queue empty.
module audio_capture_highpass_clip (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // raw_a [11:0], raw_b [23:12], raw_c [35:24], raw_d [47:36]
    input  logic [achc_pkg::S_DATA_W-1:0]       s_tdata,
    // restart [0]
    input  logic [0:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // sample_out [11:0], sample_index [27:12], zero [31:28]
    output logic [achc_pkg::M_DATA_W-1:0]       m_tdata,
    output logic                                m_tlast,
    input  logic                                cfg_we,
    input  logic [achc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [achc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    achc_pkg::coef_t                      coef_reg;
    logic [achc_pkg::CLEN_W-1:0]          clen_reg;

    logic [achc_pkg::CLEN_W-1:0]          cnt_reg;
    logic [achc_pkg::CLEN_W-1:0]          cnt_next;
    logic                                 active_reg;
    logic                                 active_next;
    logic [achc_pkg::PEND_W-1:0]          pend_reg;

    logic                                 accept;
    logic [achc_pkg::CLEN_W-1:0]          limit;
    logic [achc_pkg::CLEN_W-1:0]          cnt_eff;
    logic [achc_pkg::CLEN_W-1:0]          cnt_inc;
    logic                                 emit;
    logic                                 is_last;
    logic [achc_pkg::SUM_W-1:0]           sum;

    logic                                 v1_reg;
    logic [achc_pkg::SUM_W-1:0]           sum1_reg;
    achc_pkg::tag_t                       tag1_reg;

    achc_pkg::front_t                     front_out;
    logic                                 push;
    logic                                 pop;
    achc_pkg::result_t                    result;
    achc_pkg::result_t                    fifo_mem [achc_pkg::FIFO_DEPTH];
    logic [achc_pkg::FIFO_AW-1:0]         wr_ptr_reg;
    logic [achc_pkg::FIFO_AW-1:0]         rd_ptr_reg;
    logic [achc_pkg::PEND_W-1:0]          fifo_cnt_reg;
    achc_pkg::result_t                    head;

    assign s_tready = (pend_reg < achc_pkg::PEND_W'(achc_pkg::FIFO_DEPTH));
    assign accept   = s_tvalid && s_tready;

    // capture control
    always_comb
    begin
        limit = (clen_reg < achc_pkg::CLEN_W'(achc_pkg::MAX_SAMPLES))
              ? clen_reg : achc_pkg::CLEN_W'(achc_pkg::MAX_SAMPLES);
        cnt_eff = s_tuser[0] ? '0 : cnt_reg;
        emit    = (s_tuser[0] || active_reg) && (cnt_eff < limit);
        cnt_inc = cnt_eff + 1'b1;
        is_last = (cnt_inc >= limit);
        cnt_next    = emit ? cnt_inc : cnt_eff;
        active_next = emit && !is_last;
        sum = '0;
        for (int i = 0; i < achc_pkg::NUM_RAW; i++)
        begin
            sum = sum + achc_pkg::SUM_W'(s_tdata[i*achc_pkg::RAW_W +: achc_pkg::RAW_W]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.zero_level <= achc_pkg::ZERO_LEVEL_RST;
            coef_reg.gain       <= achc_pkg::GAIN_RST;
            coef_reg.alpha      <= achc_pkg::ALPHA_RST;
            clen_reg            <= achc_pkg::CLEN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                achc_pkg::CFG_ZERO_LEVEL: coef_reg.zero_level <= cfg_wdata[achc_pkg::DC_W-1:0];
                achc_pkg::CFG_GAIN:       coef_reg.gain       <= cfg_wdata[achc_pkg::GAIN_W-1:0];
                achc_pkg::CFG_ALPHA:      coef_reg.alpha      <= cfg_wdata[achc_pkg::ALPHA_W-1:0];
                achc_pkg::CFG_CLEN:       clen_reg            <= cfg_wdata[achc_pkg::CLEN_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            active_reg <= 1'b0;
            v1_reg     <= 1'b0;
        end
        else
        begin
            v1_reg <= accept && emit;
            if (accept)
            begin
                cnt_reg    <= cnt_next;
                active_reg <= active_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sum1_reg       <= sum;
        tag1_reg.index <= cnt_eff[achc_pkg::INDEX_W-1:0];
        tag1_reg.last  <= is_last;
    end

    achc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v1_reg),
        .sum      (sum1_reg),
        .tag      (tag1_reg),
        .coef     (coef_reg),
        .out      (front_out)
    );

    achc_filter u_filter (
        .clk    (clk),
        .rst_n  (rst_n),
        .in     (front_out),
        .alpha  (coef_reg.alpha),
        .push   (push),
        .result (result)
    );

    // output queue; pend counts kept items from acceptance until taken
    assign pop      = m_tvalid && m_tready;
    assign head     = fifo_mem[rd_ptr_reg];
    assign m_tvalid = (fifo_cnt_reg != '0);
    assign m_tdata  = {{(achc_pkg::M_DATA_W-achc_pkg::INDEX_W-achc_pkg::SAMPLE_W){1'b0}},
                       head.tag.index, head.sample};
    assign m_tlast  = head.tag.last;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
            pend_reg     <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fifo_cnt_reg <= fifo_cnt_reg + achc_pkg::PEND_W'(push) - achc_pkg::PEND_W'(pop);
            pend_reg     <= pend_reg + achc_pkg::PEND_W'(accept && emit)
                          - achc_pkg::PEND_W'(pop);
        end
    end

endmodule

// ===== hw/rtl/achc_checker.sv =====
`timescale 1ns / 1ps
// port-level checks of the capture high-pass block, bound to the top level
// depends on achc_pkg and audio_capture_highpass_clip
module achc_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [achc_pkg::M_DATA_W-1:0]       m_tdata,
    input  logic                                m_tlast
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output item withdrawn while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("output item changed while stalled");

    // clipped sample never reaches the two extreme codes
    a_clip: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[11:0] != 12'h800) && (m_tdata[11:0] != 12'h7ff))
        else $error("sample outside clip range");

    // an empty queue fills only with an item taken at the input, through the pipeline registers and the queue
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 5))
        else $error("result without matching input item");

endmodule

bind audio_capture_highpass_clip achc_checker u_checker (.*);
